// File: design/m2cd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// m2cd_pkg
// Shared types, constants and table functions of the MJD to date converter.
// ----------------------------------------------------------------------------
package m2cd_pkg;

  // first MJD handled: 1900-03-01
  localparam logic [15:0] MJD_FIRST_VALID = 16'd15079;

  // year': floor((100*mjd - Y_OFFSET) / Y_DIV)
  localparam int Y_SCALE  = 100;
  localparam int Y_OFFSET = 1507820;
  localparam int Y_DIV    = 36525;
  // reciprocal of Y_DIV at 2^Y_SHIFT, truncated; low by at most one
  localparam int Y_RECIP  = 229;
  localparam int Y_SHIFT  = 23;
  // floor(365.25*y) = floor(1461*y/4)
  localparam int Y_DAYS4  = 1461;

  localparam int DAY_BASE  = 14956;
  localparam int YEAR_BASE = 1900;

  // month': floor((10000*t - M_OFF) / M_NUM)
  localparam int M_NUM   = 306001;
  localparam int M_SCALE = 10000;
  localparam int M_OFF   = 1000;
  localparam int M_FIRST = 3;
  localparam int M_LAST  = 15;
  localparam int M_WRAP  = 12;

  typedef struct packed {
    logic        vld;
    logic        ok;
    logic [15:0] mjd;
    logic [23:0] utc;
  } m2cd_ctl_t;

  // smallest t with month' >= k
  function automatic logic [8:0] month_thr(input int k);
    month_thr = 9'((k * M_NUM + M_OFF + M_SCALE - 1) / M_SCALE);
  endfunction

  // floor(30.6001 * month') as a 16-entry table
  function automatic logic [8:0] month_days(input logic [3:0] mp);
    logic [8:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      if (mp == 4'(i)) r = 9'((i * M_NUM) / M_SCALE);
    end
    month_days = r;
  endfunction

endpackage
`default_nettype wire

// File: design/m2cd_year.sv
`default_nettype none
// ----------------------------------------------------------------------------
// m2cd_year
// Three pipeline stages computing year' = floor((100*mjd - 1507820)/36525).
// ----------------------------------------------------------------------------
module m2cd_year (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_vld,
  input  wire [15:0]           in_mjd,
  input  wire [23:0]           in_utc,
  output m2cd_pkg::m2cd_ctl_t  ctl_o,
  output logic [7:0]           yp_o
);

  m2cd_pkg::m2cd_ctl_t s1_ctl_r, s2_ctl_r, s3_ctl_r;
  logic [22:0] s1_n_r, s2_n_r;
  logic [7:0]  s2_q0_r, s3_yp_r;

  logic [22:0] n_nxt;
  logic [30:0] q_prod;
  logic [7:0]  q0_nxt;
  logic [23:0] q_back;
  logic [23:0] rem;
  logic [7:0]  yp_nxt;

  // garbage for early dates; masked at the output
  assign n_nxt  = 23'(24'(in_mjd) * 24'(m2cd_pkg::Y_SCALE) - 24'(m2cd_pkg::Y_OFFSET));
  assign q_prod = 31'(s1_n_r) * 31'(m2cd_pkg::Y_RECIP);
  assign q0_nxt = 8'(q_prod >> m2cd_pkg::Y_SHIFT);
  assign q_back = 24'(s2_q0_r) * 24'(m2cd_pkg::Y_DIV);
  assign rem    = 24'(s2_n_r) - q_back;
  assign yp_nxt = s2_q0_r + 8'(rem >= 24'(m2cd_pkg::Y_DIV));

  // only the valid bits are reset; data fields follow unconditionally
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r.vld <= 1'b0;
      s2_ctl_r.vld <= 1'b0;
      s3_ctl_r.vld <= 1'b0;
    end else begin
      s1_ctl_r.vld <= in_vld;
      s2_ctl_r.vld <= s1_ctl_r.vld;
      s3_ctl_r.vld <= s2_ctl_r.vld;
    end

    s1_ctl_r.ok  <= in_mjd >= m2cd_pkg::MJD_FIRST_VALID;
    s1_ctl_r.mjd <= in_mjd;
    s1_ctl_r.utc <= in_utc;
    s1_n_r       <= n_nxt;

    s2_ctl_r.ok  <= s1_ctl_r.ok;
    s2_ctl_r.mjd <= s1_ctl_r.mjd;
    s2_ctl_r.utc <= s1_ctl_r.utc;
    s2_n_r       <= s1_n_r;
    s2_q0_r      <= q0_nxt;

    s3_ctl_r.ok  <= s2_ctl_r.ok;
    s3_ctl_r.mjd <= s2_ctl_r.mjd;
    s3_ctl_r.utc <= s2_ctl_r.utc;
    s3_yp_r      <= yp_nxt;
  end

  assign ctl_o = s3_ctl_r;
  assign yp_o  = s3_yp_r;

endmodule
`default_nettype wire

// File: design/m2cd_month_day.sv
`default_nettype none
// ----------------------------------------------------------------------------
// m2cd_month_day
// Three pipeline stages: day offset in year, month' by threshold count,
// then day and the January/February correction.
// ----------------------------------------------------------------------------
module m2cd_month_day (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire m2cd_pkg::m2cd_ctl_t ctl_i,
  input  wire [7:0]            yp_i,
  output logic                 out_vld,
  output logic                 date_valid,
  output logic [10:0]          year,
  output logic [3:0]           month,
  output logic [4:0]           day,
  output logic [23:0]          utc
);

  m2cd_pkg::m2cd_ctl_t s4_ctl_r, s5_ctl_r;
  logic [7:0]  s4_yp_r, s5_yp_r;
  logic [8:0]  s4_t_r, s5_t_r;
  logic [3:0]  s5_mp_r;

  logic        s6_vld_r, s6_ok_r;
  logic [10:0] s6_year_r;
  logic [3:0]  s6_month_r;
  logic [4:0]  s6_day_r;
  logic [23:0] s6_utc_r;

  logic [17:0] yd_prod;
  logic [16:0] t_full;
  logic [3:0]  mp_nxt;
  logic        wrap;
  logic [8:0]  d_full;

  assign yd_prod = 18'(yp_i) * 18'(m2cd_pkg::Y_DAYS4);
  assign t_full  = 17'(ctl_i.mjd) - 17'(m2cd_pkg::DAY_BASE) - 17'(yd_prod[17:2]);

  // thresholds rise with k, so the count of passed ones is month'
  always_comb begin
    mp_nxt = 4'(m2cd_pkg::M_FIRST);
    for (int k = m2cd_pkg::M_FIRST + 1; k <= m2cd_pkg::M_LAST; k++) begin
      mp_nxt = mp_nxt + 4'(s4_t_r >= m2cd_pkg::month_thr(k));
    end
  end

  assign wrap   = (s5_mp_r == 4'(m2cd_pkg::M_LAST - 1)) || (s5_mp_r == 4'(m2cd_pkg::M_LAST));
  assign d_full = s5_t_r - m2cd_pkg::month_days(s5_mp_r);

  // only the valid bits are reset; data fields follow unconditionally
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_ctl_r.vld <= 1'b0;
      s5_ctl_r.vld <= 1'b0;
      s6_vld_r     <= 1'b0;
    end else begin
      s4_ctl_r.vld <= ctl_i.vld;
      s5_ctl_r.vld <= s4_ctl_r.vld;
      s6_vld_r     <= s5_ctl_r.vld;
    end

    s4_ctl_r.ok  <= ctl_i.ok;
    s4_ctl_r.mjd <= ctl_i.mjd;
    s4_ctl_r.utc <= ctl_i.utc;
    s4_yp_r      <= yp_i;
    s4_t_r       <= t_full[8:0];

    s5_ctl_r.ok  <= s4_ctl_r.ok;
    s5_ctl_r.mjd <= s4_ctl_r.mjd;
    s5_ctl_r.utc <= s4_ctl_r.utc;
    s5_yp_r      <= s4_yp_r;
    s5_t_r       <= s4_t_r;
    s5_mp_r      <= mp_nxt;

    s6_ok_r  <= s5_ctl_r.ok;
    s6_utc_r <= s5_ctl_r.utc;
    if (s5_ctl_r.ok) begin
      s6_year_r  <= 11'(s5_yp_r) + 11'(wrap) + 11'(m2cd_pkg::YEAR_BASE);
      s6_month_r <= s5_mp_r - 4'd1 - (wrap ? 4'(m2cd_pkg::M_WRAP) : 4'd0);
      s6_day_r   <= d_full[4:0];
    end else begin
      s6_year_r  <= '0;
      s6_month_r <= '0;
      s6_day_r   <= '0;
    end
  end

  assign out_vld    = s6_vld_r;
  assign date_valid = s6_ok_r;
  assign year       = s6_year_r;
  assign month      = s6_month_r;
  assign day        = s6_day_r;
  assign utc        = s6_utc_r;

endmodule
`default_nettype wire

// File: design/mjd_to_calendar_date_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mjd_to_calendar_date_core
// DVB 40-bit time stamp to calendar date with BCD time passthrough.
// ----------------------------------------------------------------------------
// Takes one time stamp per clock: busy is always low, so every start is a
// transfer. Each result appears on the out_ ports for one cycle with
// out_strobe high, at the end of the six-stage pipeline (three stages for
// the year division, three for month and day). Results cannot be held off;
// capture them when the strobe is seen. Dates before 1900-03-01 come back
// with out_date_valid low and zero date fields.
module mjd_to_calendar_date_core (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  output logic        busy,
  input  wire  [15:0] in_mjd,
  input  wire  [23:0] in_utc_bcd,
  output logic        out_strobe,
  output logic        out_date_valid,
  output logic [10:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day,
  output logic [7:0]  out_hour_bcd,
  output logic [7:0]  out_minute_bcd,
  output logic [7:0]  out_second_bcd
);

  m2cd_pkg::m2cd_ctl_t yr_ctl;
  logic [7:0]  yr_yp;
  logic        in_xfer;
  logic [23:0] out_utc;

  assign busy    = 1'b0;
  assign in_xfer = start && !busy;

  m2cd_year u_year (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (in_xfer),
    .in_mjd (in_mjd),
    .in_utc (in_utc_bcd),
    .ctl_o  (yr_ctl),
    .yp_o   (yr_yp)
  );

  m2cd_month_day u_month_day (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl_i      (yr_ctl),
    .yp_i       (yr_yp),
    .out_vld    (out_strobe),
    .date_valid (out_date_valid),
    .year       (out_year),
    .month      (out_month),
    .day        (out_day),
    .utc        (out_utc)
  );

  assign out_hour_bcd   = out_utc[23:16];
  assign out_minute_bcd = out_utc[15:8];
  assign out_second_bcd = out_utc[7:0];

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> ##6 out_strobe)
    else $error("transfer did not produce a result after six cycles");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_date_valid |->
      out_month >= 4'd1 && out_month <= 4'd12 && out_day >= 5'd1 &&
      out_year >= 11'd1900 && out_year <= 11'd2039)
    else $error("valid date out of range");

  a_early_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_date_valid |->
      out_year == 11'd0 && out_month == 4'd0 && out_day == 5'd0)
    else $error("invalid date with nonzero fields");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(in_xfer, 6))
    else $error("result without a matching transfer");

endmodule
`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the MJD to calendar date converter against a built-in date predictor.
// ----------------------------------------------------------------------------
// Stamps are sent through the start/busy handshake with random gaps and
// with gap-free bursts. Each result is matched to the oldest pending stamp.
// Directed stamps cover the first valid day, year, month and leap-day
// boundaries, the top of the MJD range and early dates. Random stamps
// follow, with both valid BCD times and raw time bytes.
module testbench;

  localparam int PERIOD_NS     = 10;
  localparam int RESET_CYCLES  = 8;
  localparam int MAX_GAP       = 4;
  localparam int STALL_LIMIT   = 200;
  localparam int DRAIN_CYCLES  = 12;
  localparam int RANDOM_STAMPS = 1930;

  // Annex C constants as scaled integers
  localparam logic [15:0] FIRST_DATE_MJD = 16'd15079;
  localparam longint YEAR_SCALE  = 100;
  localparam longint YEAR_OFFSET = 1507820;
  localparam longint YEAR_DIV    = 36525;
  localparam longint QUAD_DAYS   = 1461;
  localparam longint DAY_BASE    = 14956;
  localparam longint MONTH_SCALE = 10000;
  localparam longint MONTH_OFF   = 1000;
  localparam longint MONTH_NUM   = 306001;
  localparam longint YEAR_BASE   = 1900;

  typedef struct packed {
    logic        date_valid;
    logic [10:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [7:0]  hour_bcd;
    logic [7:0]  minute_bcd;
    logic [7:0]  second_bcd;
  } date_result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] in_mjd = '0;
  logic [23:0] in_utc_bcd = '0;
  logic        out_strobe;
  logic        out_date_valid;
  logic [10:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic [7:0]  out_hour_bcd;
  logic [7:0]  out_minute_bcd;
  logic [7:0]  out_second_bcd;

  date_result_t pending_dates[$];
  int           mismatch_count = 0;
  int           stamps_sent = 0;
  int           early_stamps = 0;
  int           dates_checked = 0;
  int           stall_cycles = 0;
  bit           no_gaps = 1'b0;

  mjd_to_calendar_date_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mjd         (in_mjd),
    .in_utc_bcd     (in_utc_bcd),
    .out_strobe     (out_strobe),
    .out_date_valid (out_date_valid),
    .out_year       (out_year),
    .out_month      (out_month),
    .out_day        (out_day),
    .out_hour_bcd   (out_hour_bcd),
    .out_minute_bcd (out_minute_bcd),
    .out_second_bcd (out_second_bcd)
  );

  initial begin
    clk = 1'b0;
    forever #(PERIOD_NS / 2) clk = ~clk;
  end

  function automatic date_result_t predict_date(input logic [15:0] mjd,
                                                input logic [23:0] utc);
    date_result_t r;
    longint days, yp, year_days, mp, month_days, carry;
    r = '0;
    r.hour_bcd   = utc[23:16];
    r.minute_bcd = utc[15:8];
    r.second_bcd = utc[7:0];
    if (mjd >= FIRST_DATE_MJD) begin
      // all numerators are non-negative from the first valid day on,
      // so truncating division is the floor
      days       = longint'(mjd);
      yp         = (YEAR_SCALE * days - YEAR_OFFSET) / YEAR_DIV;
      year_days  = (QUAD_DAYS * yp) / 4;
      mp         = (MONTH_SCALE * (days - DAY_BASE - year_days) - MONTH_OFF) / MONTH_NUM;
      month_days = (MONTH_NUM * mp) / MONTH_SCALE;
      // January and February count as months 13 and 14 of the prior year
      carry      = (mp == 14 || mp == 15) ? 1 : 0;
      r.date_valid = 1'b1;
      r.year       = 11'(yp + carry + YEAR_BASE);
      r.month      = 4'(mp - 1 - 12 * carry);
      r.day        = 5'(days - DAY_BASE - year_days - month_days);
    end
    return r;
  endfunction

  function automatic logic [7:0] to_bcd(input int unsigned value);
    return {4'(value / 10), 4'(value % 10)};
  endfunction

  task automatic send_stamp(input logic [15:0] mjd, input logic [23:0] utc);
    int  gap;
    bit  was_busy;
    gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    in_mjd     <= mjd;
    in_utc_bcd <= utc;
    forever begin
      @(negedge clk);
      was_busy = busy;
      @(posedge clk);
      if (!was_busy) break;
    end
    pending_dates.push_back(predict_date(mjd, utc));
    stamps_sent++;
    if (mjd < FIRST_DATE_MJD) early_stamps++;
  endtask

  task automatic test_early_dates();
    send_stamp(16'd0,     24'h000000);
    send_stamp(16'd1,     24'hFFFFFF);
    send_stamp(16'd15078, 24'h235959);
    send_stamp(16'd7539,  24'hAAAAAA);
  endtask

  task automatic test_calendar_boundaries();
    send_stamp(16'd15079, 24'h000000);   // 1900-03-01
    send_stamp(16'd15080, 24'h555555);
    send_stamp(16'd15384, 24'h235959);   // end of 1900
    send_stamp(16'd15385, 24'h000001);
    send_stamp(16'd15443, 24'h120000);   // end of February, common year
    send_stamp(16'd15444, 24'h123456);
    send_stamp(16'd40587, 24'h000000);
    send_stamp(16'd49273, 24'h124527);
    send_stamp(16'd51543, 24'h235959);
    send_stamp(16'd51544, 24'h000000);
    send_stamp(16'd51603, 24'h065432);   // leap day 2000
    send_stamp(16'd51604, 24'h999999);
    send_stamp(16'd32768, 24'h800000);
  endtask

  task automatic test_range_top();
    send_stamp(16'd65534, 24'h7F7F7F);
    send_stamp(16'd65535, 24'hFFFFFF);
    send_stamp(16'd65535, 24'h000000);
  endtask

  task automatic test_random_stamps(input int count);
    logic [15:0] mjd;
    logic [23:0] utc;
    for (int i = 0; i < count; i++) begin
      // alternate stretches of random gaps with gap-free bursts
      if (i % 48 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0: mjd = 16'($urandom_range(0, FIRST_DATE_MJD - 1));
        1: mjd = FIRST_DATE_MJD + 16'($urandom_range(0, 40));
        2: mjd = 16'hFFFF - 16'($urandom_range(0, 40));
        3: mjd = 16'($urandom);
        default: mjd = 16'($urandom_range(FIRST_DATE_MJD, 16'hFFFF));
      endcase
      if ($urandom_range(0, 1) == 0) begin
        utc = {to_bcd($urandom_range(0, 23)), to_bcd($urandom_range(0, 59)),
               to_bcd($urandom_range(0, 59))};
      end else begin
        utc = 24'($urandom);
      end
      send_stamp(mjd, utc);
    end
    no_gaps = 1'b0;
  endtask

  // results are stable for the whole strobe cycle; sample mid-cycle
  always @(negedge clk) begin
    date_result_t exp_date;
    if (rst_n && out_strobe) begin
      if (pending_dates.size() == 0) begin
        $error("result with no pending stamp: year %0d month %0d day %0d",
               out_year, out_month, out_day);
        mismatch_count++;
      end else begin
        exp_date = pending_dates.pop_front();
        dates_checked++;
        if (out_date_valid !== exp_date.date_valid) begin
          $error("date_valid: expected %0b, got %0b", exp_date.date_valid, out_date_valid);
          mismatch_count++;
        end
        if (out_year !== exp_date.year) begin
          $error("year: expected %0d, got %0d", exp_date.year, out_year);
          mismatch_count++;
        end
        if (out_month !== exp_date.month) begin
          $error("month: expected %0d, got %0d", exp_date.month, out_month);
          mismatch_count++;
        end
        if (out_day !== exp_date.day) begin
          $error("day: expected %0d, got %0d", exp_date.day, out_day);
          mismatch_count++;
        end
        if (out_hour_bcd !== exp_date.hour_bcd) begin
          $error("hour_bcd: expected %h, got %h", exp_date.hour_bcd, out_hour_bcd);
          mismatch_count++;
        end
        if (out_minute_bcd !== exp_date.minute_bcd) begin
          $error("minute_bcd: expected %h, got %h", exp_date.minute_bcd, out_minute_bcd);
          mismatch_count++;
        end
        if (out_second_bcd !== exp_date.second_bcd) begin
          $error("second_bcd: expected %h, got %h", exp_date.second_bcd, out_second_bcd);
          mismatch_count++;
        end
      end
    end
  end

  // stall watchdog: cycles with neither an input transfer nor a result
  always @(negedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("FAIL mjd_to_calendar_date_core");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_early_dates();
    test_calendar_boundaries();
    test_range_top();
    test_random_stamps(RANDOM_STAMPS);

    start <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d time stamps, %0d of them before 1900-03-01.",
             stamps_sent, early_stamps);
    $display("Checked %0d results field by field, %0d mismatches.",
             dates_checked, mismatch_count);
    if (mismatch_count == 0 && pending_dates.size() == 0) begin
      $display("PASS mjd_to_calendar_date_core");
    end else begin
      $display("FAIL mjd_to_calendar_date_core");
    end
    $finish;
  end

endmodule

// File: mjd_to_calendar_date_core.f
design/m2cd_pkg.sv
design/m2cd_year.sv
design/m2cd_month_day.sv
design/mjd_to_calendar_date_core.sv
verif/testbench.sv
